// ===== hdl/indexed_array_insert_erase_macros.svh =====
// ----------------------------------------------------------------------------
// indexed_array_insert_erase assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ARRAY_INSERT_ERASE_MACROS_SVH
`define INDEXED_ARRAY_INSERT_ERASE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define IAIE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define IAIE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/iaie_pkg.sv =====
// ----------------------------------------------------------------------------
// iaie_pkg
// Shared widths, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package iaie_pkg;

	localparam int DEPTH_DEF = 1024;

	localparam int FUNC_W = 2;
	localparam int IDX_W  = 11;
	localparam int CNT_W  = 11;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int SIZE_W = 11;
	localparam int CAP_W  = 12;

	// stream payload widths, rounded up to whole bytes
	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 56;

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT = 2'd0,
		FN_ERASE  = 2'd1,
		FN_GET    = 2'd2,
		FN_SET    = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_IGNORE = 2'd1,
		ST_RANGE  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_UP    = 7'b0000010,
		S_DOWN  = 7'b0000100,
		S_DRAIN = 7'b0001000,
		S_PUT   = 7'b0010000,
		S_READ  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

endpackage

// ===== hdl/iaie_ram.sv =====
// ----------------------------------------------------------------------------
// iaie_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module iaie_ram #(
	parameter int WIDTH = iaie_pkg::VAL_W,
	parameter int DEPTH = iaie_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/indexed_array_insert_erase.sv =====
// ----------------------------------------------------------------------------
// indexed_array_insert_erase
// Ordered store of signed 32-bit words with insert, erase, get and set.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transaction per operation; s_tuser carries the
//   operation, s_tdata the index, count and value. Output stream (m_*): one
//   transaction per operation with read value, size and capacity in m_tdata
//   and the status code in m_tuser.
//   One operation is in flight at a time; s_tready is high only while the
//   sequencer is idle. Elements live in a single RAM; insert and erase move
//   the tail one element per cycle through that RAM's ports, so the time per
//   transaction is set by that shift loop. States visited per operation:
//     insert : S_UP, S_DRAIN, S_PUT, S_DONE when a move is needed, else
//              S_PUT, S_DONE
//     erase  : S_DOWN, S_DRAIN, S_DONE when a move is needed, else S_DONE
//     get S_READ, S_DONE; set S_PUT, S_DONE; rejected operations S_DONE
//   After the result is registered the block is ready again the next cycle.
//   Reset: size clears to 0 and capacity to 1; RAM contents are not cleared
//   and are never read below the size without having been written.
//   A stalled receiver holds the result in the output register; the next
//   operation is still accepted and runs, and only its final result step
//   waits until the previous result is taken.
// ----------------------------------------------------------------------------
`include "indexed_array_insert_erase_macros.svh"

module indexed_array_insert_erase #(
	parameter int DEPTH = iaie_pkg::DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [10:0] index, [21:11] count, [53:22] value, [55:54] zero
	input  logic [iaie_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] func
	input  logic [iaie_pkg::FUNC_W-1:0]    s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [31:0] read_value, [42:32] cur_size, [54:43] cur_capacity, [55] zero
	output logic [iaie_pkg::M_TDATA_W-1:0] m_tdata,
	// [1:0] status
	output logic [iaie_pkg::STAT_W-1:0]    m_tuser
);

	localparam int AW = $clog2(DEPTH);        // RAM address
	localparam int SW = $clog2(DEPTH + 1);    // element count, 0..DEPTH
	localparam int KW = $clog2(DEPTH) + 2;    // capacity, up to 2*DEPTH
	localparam int CW = (SW > iaie_pkg::IDX_W) ? SW : iaie_pkg::IDX_W;

	// input unpack
	iaie_pkg::func_t                   in_func;
	logic [iaie_pkg::IDX_W-1:0]        in_index;
	logic [iaie_pkg::CNT_W-1:0]        in_count;
	logic signed [iaie_pkg::VAL_W-1:0] in_value;

	assign in_func  = iaie_pkg::func_t'(s_tuser);
	assign in_index = s_tdata[10:0];
	assign in_count = s_tdata[21:11];
	assign in_value = s_tdata[53:22];

	// control state
	iaie_pkg::state_t state_q;
	logic [SW-1:0]    size_q;
	logic [KW-1:0]    cap_q;
	logic             pend_q;      // RAM read data due to be written this cycle
	logic             out_valid_q;

	// operation context
	iaie_pkg::func_t                   func_q;
	iaie_pkg::status_t                 status_q;
	logic [AW-1:0]                     idx_q;
	logic signed [iaie_pkg::VAL_W-1:0] value_q;
	logic [AW-1:0]                     ptr_q;       // read pointer of the shift loop
	logic [AW-1:0]                     dst_q;       // erase destination
	logic [AW-1:0]                     end_q;       // last source of an erase
	logic [AW-1:0]                     pend_addr_q;

	// result register
	logic [iaie_pkg::VAL_W-1:0]  out_value_q;
	iaie_pkg::status_t           out_status_q;
	logic [iaie_pkg::SIZE_W-1:0] out_size_q;
	logic [iaie_pkg::CAP_W-1:0]  out_cap_q;

	// admission checks, all at CW bits
	logic [CW-1:0] idx_x;
	logic [CW-1:0] size_x;
	logic [CW-1:0] cnt_x;
	logic [CW-1:0] avail_x;   // elements from index to end
	logic [CW-1:0] rem_x;     // elements actually erased
	logic [CW-1:0] src_x;     // first element that moves down
	logic          accept;
	logic          out_free;

	assign idx_x   = CW'(in_index);
	assign size_x  = CW'(size_q);
	assign cnt_x   = CW'(in_count);
	assign avail_x = size_x - idx_x;
	assign rem_x   = (cnt_x < avail_x) ? cnt_x : avail_x;
	assign src_x   = idx_x + rem_x;

	assign s_tready = (state_q == iaie_pkg::S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// RAM ports
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [iaie_pkg::VAL_W-1:0] ram_wdata;
	logic [AW-1:0]              ram_raddr;
	logic [iaie_pkg::VAL_W-1:0] ram_rdata;

	always_comb begin
		ram_we    = pend_q || (state_q == iaie_pkg::S_PUT);
		ram_waddr = pend_q ? pend_addr_q : idx_q;
		ram_wdata = pend_q ? ram_rdata : value_q;
		ram_raddr = (state_q == iaie_pkg::S_UP || state_q == iaie_pkg::S_DOWN) ? ptr_q : idx_q;
	end

	iaie_ram #(
		.WIDTH (iaie_pkg::VAL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iaie_pkg::S_IDLE;
			size_q      <= '0;
			cap_q       <= KW'(1);
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= 1'b0;
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				iaie_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= iaie_pkg::S_DONE;
						unique case (in_func)
							iaie_pkg::FN_INSERT: begin
								if (idx_x <= size_x && size_q != SW'(DEPTH)) begin
									state_q <= (idx_x == size_x) ? iaie_pkg::S_PUT
										: iaie_pkg::S_UP;
								end
							end
							iaie_pkg::FN_ERASE: begin
								if (idx_x < size_x) begin
									size_q <= size_q - SW'(rem_x);
									// tail moves only when something is erased
									// and something lies beyond the erased run
									if (rem_x != '0 && src_x != size_x) begin
										state_q <= iaie_pkg::S_DOWN;
									end
								end
							end
							iaie_pkg::FN_GET: begin
								if (idx_x < size_x) begin
									state_q <= iaie_pkg::S_READ;
								end
							end
							iaie_pkg::FN_SET: begin
								if (idx_x < size_x) begin
									state_q <= iaie_pkg::S_PUT;
								end
							end
							default: ;
						endcase
					end
				end
				iaie_pkg::S_UP: begin
					pend_q <= 1'b1;
					if (ptr_q == idx_q) begin
						state_q <= iaie_pkg::S_DRAIN;
					end
				end
				iaie_pkg::S_DOWN: begin
					pend_q <= 1'b1;
					if (ptr_q == end_q) begin
						state_q <= iaie_pkg::S_DRAIN;
					end
				end
				iaie_pkg::S_DRAIN: begin
					state_q <= (func_q == iaie_pkg::FN_INSERT) ? iaie_pkg::S_PUT
						: iaie_pkg::S_DONE;
				end
				iaie_pkg::S_PUT: begin
					if (func_q == iaie_pkg::FN_INSERT) begin
						size_q <= size_q + SW'(1);
						// capacity stays above size: it doubles when the insert fills it
						if (cap_q == KW'(size_q) + KW'(1)) begin
							cap_q <= cap_q << 1;
						end
					end
					state_q <= iaie_pkg::S_DONE;
				end
				iaie_pkg::S_READ: begin
					state_q <= iaie_pkg::S_DONE;
				end
				iaie_pkg::S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= iaie_pkg::S_IDLE;
					end
				end
				default: state_q <= iaie_pkg::S_IDLE;
			endcase
		end
	end

	// operation context and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= in_func;
			idx_q   <= AW'(in_index);
			value_q <= in_value;
			status_q <= iaie_pkg::ST_OK;
			unique case (in_func)
				iaie_pkg::FN_INSERT: begin
					if (idx_x > size_x) begin
						status_q <= iaie_pkg::ST_IGNORE;
					end else if (size_q == SW'(DEPTH)) begin
						status_q <= iaie_pkg::ST_FULL;
					end
					ptr_q <= AW'(size_q - SW'(1));
				end
				iaie_pkg::FN_ERASE: begin
					if (idx_x >= size_x) begin
						status_q <= iaie_pkg::ST_IGNORE;
					end
					ptr_q <= AW'(src_x);
					dst_q <= AW'(in_index);
					end_q <= AW'(size_q - SW'(1));
				end
				iaie_pkg::FN_GET, iaie_pkg::FN_SET: begin
					if (idx_x >= size_x) begin
						status_q <= iaie_pkg::ST_RANGE;
					end
				end
				default: ;
			endcase
		end
		if (state_q == iaie_pkg::S_UP) begin
			pend_addr_q <= ptr_q + AW'(1);
			ptr_q       <= ptr_q - AW'(1);
		end
		if (state_q == iaie_pkg::S_DOWN) begin
			pend_addr_q <= dst_q;
			ptr_q       <= ptr_q + AW'(1);
			dst_q       <= dst_q + AW'(1);
		end
		if (state_q == iaie_pkg::S_DONE && out_free) begin
			out_value_q  <= (func_q == iaie_pkg::FN_GET && status_q == iaie_pkg::ST_OK)
				? ram_rdata : '0;
			out_status_q <= status_q;
			out_size_q   <= iaie_pkg::SIZE_W'(size_q);
			out_cap_q    <= iaie_pkg::CAP_W'(cap_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_cap_q, out_size_q, out_value_q};
	assign m_tuser  = out_status_q;

	// checks
	`IAIE_ASSERT_NOW(a_size_bound, 1'b1, size_q <= SW'(DEPTH), "size above DEPTH")
	`IAIE_ASSERT_NOW(a_cap_above_size, 1'b1, cap_q > KW'(size_q), "capacity not above size")
	`IAIE_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "ready right after accept")
	`IAIE_ASSERT_NOW(a_no_write_idle, state_q == iaie_pkg::S_IDLE, !ram_we, "RAM write while idle")

endmodule
